@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL top level.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define QPP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define QPP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/qpp_pkg.sv @@
`default_nettype none
package qpp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int ACC_W       = VALUE_WIDTH + 4;  // holds acc*10 + 9
  localparam int KEY_LEN     = 4;
  localparam int KEY_POS_W   = 3;

  localparam logic [7:0] CH_AMP  = 8'h26;  // '&'
  localparam logic [7:0] CH_EQ   = 8'h3d;  // '='
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [7:0] NAME_PAGE [KEY_LEN] = '{8'h70, 8'h61, 8'h67, 8'h65};
  localparam logic [7:0] NAME_SIZE [KEY_LEN] = '{8'h73, 8'h69, 8'h7a, 8'h65};

  // Byte classes
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_AMP   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EQ    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIGIT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OTHER = 3'd4;

  // Result status
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_PAGE = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

  // Config registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PAGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT    = 2'd2;

  localparam logic [31:0] RST_DEFAULT_PAGE  = 32'd1;
  localparam logic [31:0] RST_FALLBACK_SIZE = 32'd20;
  localparam logic [31:0] RST_SIZE_LIMIT    = 32'd100;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [3:0]         digit;
    logic [KEY_LEN-1:0] page_hit;  // byte matches "page" at each key position
    logic [KEY_LEN-1:0] size_hit;  // byte matches "size" at each key position
    logic               last;
  } qpp_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qpp_q_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/qpp_channels.sv @@
`default_nettype none
interface qpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, output query_byte, output has_byte, output last_byte,
                  input ready);
  modport sink (input valid, input query_byte, input has_byte, input last_byte,
                output ready);
endinterface

interface qpp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] page_number;
  logic [31:0] page_size;

  modport source (output valid, output status, output page_number, output page_size,
                  input ready);
  modport sink (input valid, input status, input page_number, input page_size,
                output ready);
endinterface

interface qpp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [qpp_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/qpp_front.sv @@
`default_nettype none
module qpp_front (
  qpp_in_if.sink              query,
  output logic                item_valid,
  output qpp_pkg::qpp_item_t  item,
  input  logic                item_ready
);
  import qpp_pkg::*;

  assign query.ready = item_ready;
  assign item_valid  = query.valid;

  // Classify the byte; key matching against both names is done for every
  // position so the back end only selects by its key counter.
  always_comb begin
    item.last  = query.last_byte;
    item.digit = query.query_byte[3:0];
    if (!query.has_byte) begin
      item.kind = KIND_NONE;
    end else if (query.query_byte == CH_AMP) begin
      item.kind = KIND_AMP;
    end else if (query.query_byte == CH_EQ) begin
      item.kind = KIND_EQ;
    end else if (query.query_byte >= CH_ZERO && query.query_byte <= CH_NINE) begin
      item.kind = KIND_DIGIT;
    end else begin
      item.kind = KIND_OTHER;
    end
    for (int i = 0; i < KEY_LEN; i++) begin
      item.page_hit[i] = (query.query_byte == NAME_PAGE[i]);
      item.size_hit[i] = (query.query_byte == NAME_SIZE[i]);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/qpp_queue.sv @@
`default_nettype none
module qpp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  input  qpp_pkg::qpp_item_t   wr_item,
  output logic                 wr_ready,
  output logic                 rd_valid,
  output qpp_pkg::qpp_item_t   rd_item,
  input  logic                 rd_ready,
  output qpp_pkg::qpp_q_stat_t stat
);
  import qpp_pkg::*;

  qpp_item_t              mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  assign wr_ready   = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd_valid   = (count != '0);
  assign rd_item    = mem[rd_ptr];
  assign push       = wr_valid && wr_ready;
  assign pop        = rd_valid && rd_ready;
  assign stat.full  = !wr_ready;
  assign stat.empty = !rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/qpp_back.sv @@
`default_nettype none
module qpp_back (
  input  logic               clk,
  input  logic               rst,
  qpp_cfg_if.sink            cfg,
  input  logic               rd_valid,
  input  qpp_pkg::qpp_item_t rd_item,
  output logic               rd_ready,
  qpp_out_if.source          result
);
  import qpp_pkg::*;

  // Config registers
  logic [31:0] default_page;
  logic [31:0] fallback_size;
  logic [31:0] size_limit;

  // Parse state
  logic                   in_value,          in_value_next;
  logic [KEY_POS_W-1:0]   key_position,      key_position_next;
  logic                   key_may_be_page,   key_may_be_page_next;
  logic                   key_may_be_size,   key_may_be_size_next;
  logic [VALUE_WIDTH-1:0] value_accumulator, value_accumulator_next;
  logic                   value_good,        value_good_next;
  logic                   page_seen,         page_seen_next;
  logic                   size_seen,         size_seen_next;
  logic [VALUE_WIDTH-1:0] page_value,        page_value_next;
  logic [VALUE_WIDTH-1:0] size_value,        size_value_next;
  logic                   page_valid,        page_valid_next;
  logic                   size_valid,        size_valid_next;

  // Output register
  logic        out_valid;
  logic [1:0]  status,      status_next;
  logic [31:0] page_number, page_number_next;
  logic [31:0] page_size,   page_size_next;
  logic        load_result;
  logic        take;
  logic [ACC_W-1:0] acc_step;

  assign cfg.ready          = 1'b1;
  assign rd_ready           = !rd_item.last || !out_valid || result.ready;
  assign take               = rd_valid && rd_ready;
  assign result.valid       = out_valid;
  assign result.status      = status;
  assign result.page_number = page_number;
  assign result.page_size   = page_size;

  // acc*10 + digit as two shifts and two adds
  assign acc_step = {1'b0, value_accumulator, 3'b000} + {3'b000, value_accumulator, 1'b0}
                  + {{(ACC_W-4){1'b0}}, rd_item.digit};

  always_comb begin
    logic pair_ok;
    in_value_next          = in_value;
    key_position_next      = key_position;
    key_may_be_page_next   = key_may_be_page;
    key_may_be_size_next   = key_may_be_size;
    value_accumulator_next = value_accumulator;
    value_good_next        = value_good;
    page_seen_next         = page_seen;
    size_seen_next         = size_seen;
    page_value_next        = page_value;
    size_value_next        = size_value;
    page_valid_next        = page_valid;
    size_valid_next        = size_valid;
    load_result            = 1'b0;
    status_next            = STATUS_OK;
    page_number_next       = '0;
    page_size_next         = '0;
    pair_ok                = 1'b0;

    if (take) begin
      // Byte update
      case (rd_item.kind)
        KIND_EQ: begin
          if (!in_value) begin
            key_may_be_page_next   = key_may_be_page && (key_position == KEY_POS_W'(KEY_LEN));
            key_may_be_size_next   = key_may_be_size && (key_position == KEY_POS_W'(KEY_LEN));
            in_value_next          = 1'b1;
            key_position_next      = '0;
            value_accumulator_next = '0;
            value_good_next        = 1'b1;
          end else begin
            value_good_next = 1'b0;
          end
        end
        KIND_DIGIT, KIND_OTHER: begin
          if (!in_value) begin
            if (key_position < KEY_POS_W'(KEY_LEN)) begin
              key_may_be_page_next = key_may_be_page && rd_item.page_hit[key_position[1:0]];
              key_may_be_size_next = key_may_be_size && rd_item.size_hit[key_position[1:0]];
              key_position_next    = key_position + KEY_POS_W'(1);
            end else begin
              key_may_be_page_next = 1'b0;
              key_may_be_size_next = 1'b0;
            end
          end else if (rd_item.kind == KIND_DIGIT) begin
            key_position_next = KEY_POS_W'(1);
            if (value_good) begin
              if (|acc_step[ACC_W-1:VALUE_WIDTH]) begin
                value_good_next = 1'b0;
              end else begin
                value_accumulator_next = acc_step[VALUE_WIDTH-1:0];
              end
            end
          end else begin
            value_good_next = 1'b0;
          end
        end
        default: begin
          // '&' is handled as a pair end below; no byte changes nothing
        end
      endcase

      // Pair end on '&' or end of query
      if (rd_item.kind == KIND_AMP || rd_item.last) begin
        if (in_value_next) begin
          pair_ok = value_good_next && (key_position_next != '0);
          if (key_may_be_page_next && !page_seen) begin
            page_seen_next  = 1'b1;
            page_value_next = value_accumulator_next;
            page_valid_next = pair_ok;
          end else if (key_may_be_size_next && !size_seen) begin
            size_seen_next  = 1'b1;
            size_value_next = value_accumulator_next;
            size_valid_next = pair_ok;
          end
        end
        in_value_next          = 1'b0;
        key_position_next      = '0;
        key_may_be_page_next   = 1'b1;
        key_may_be_size_next   = 1'b1;
        value_accumulator_next = '0;
        value_good_next        = 1'b0;
      end

      // Result and query clear
      if (rd_item.last) begin
        load_result = 1'b1;
        if (page_seen_next && (!page_valid_next || page_value_next == '0)) begin
          status_next = STATUS_BAD_PAGE;
        end else if (size_seen_next && (!size_valid_next || size_value_next == '0 ||
                                        size_value_next > size_limit)) begin
          status_next = STATUS_BAD_SIZE;
        end else begin
          status_next      = STATUS_OK;
          page_number_next = page_seen_next ? page_value_next : default_page;
          page_size_next   = size_seen_next ? size_value_next : fallback_size;
        end
        page_seen_next  = 1'b0;
        size_seen_next  = 1'b0;
        page_value_next = '0;
        size_value_next = '0;
        page_valid_next = 1'b0;
        size_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_page  <= RST_DEFAULT_PAGE;
      fallback_size <= RST_FALLBACK_SIZE;
      size_limit    <= RST_SIZE_LIMIT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DEFAULT_PAGE:  default_page  <= cfg.data;
        CFG_FALLBACK_SIZE: fallback_size <= cfg.data;
        CFG_SIZE_LIMIT:    size_limit    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value          <= 1'b0;
      key_position      <= '0;
      key_may_be_page   <= 1'b1;
      key_may_be_size   <= 1'b1;
      value_accumulator <= '0;
      value_good        <= 1'b0;
      page_seen         <= 1'b0;
      size_seen         <= 1'b0;
      page_value        <= '0;
      size_value        <= '0;
      page_valid        <= 1'b0;
      size_valid        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      in_value          <= in_value_next;
      key_position      <= key_position_next;
      key_may_be_page   <= key_may_be_page_next;
      key_may_be_size   <= key_may_be_size_next;
      value_accumulator <= value_accumulator_next;
      value_good        <= value_good_next;
      page_seen         <= page_seen_next;
      size_seen         <= size_seen_next;
      page_value        <= page_value_next;
      size_value        <= size_value_next;
      page_valid        <= page_valid_next;
      size_valid        <= size_valid_next;
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      status      <= status_next;
      page_number <= page_number_next;
      page_size   <= page_size_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/query_pagination_parser_core.sv @@
// Pagination query parser, top level.
// query:  one transaction per query byte (query_byte, has_byte, last_byte).
//         has_byte low with last_byte high ends a query without a character.
// result: one transaction per query, on its last byte: status, page_number,
//         page_size. Fields are zero when status is not ok.
// cfg:    register writes (0 default_page, 1 fallback_size, 2 size_limit); always
//         ready, write only while no query is in flight.
// Throughput: one byte per cycle unless a last byte waits on a held result; the
// accumulator update (acc*10 + digit, overflow check) is combinational in the back end.
// Path: a last byte is written into the byte queue, then the back end takes it
// and loads the output register; result.valid comes from that register.
// Stall: the output register holds a result until taken. Bytes that do not end
// a query keep flowing; a last byte waits in the two-entry queue, and query.ready
// drops once that queue is full.
// Reset: synchronous, clears the parse state, the queue and the result valid;
// config registers return to 1, 20 and 100.
`default_nettype none
`include "assert_macros.svh"
module query_pagination_parser_core (
  input  logic      clk,
  input  logic      rst,
  qpp_in_if.sink    query,
  qpp_out_if.source result,
  qpp_cfg_if.sink   cfg
);
  import qpp_pkg::*;

  // Front end to queue
  logic        fr_valid;
  logic        fr_ready;
  qpp_item_t   fr_item;

  // Queue to back end
  logic        bk_valid;
  logic        bk_ready;
  qpp_item_t   bk_item;
  qpp_q_stat_t q_stat;

  // Assertion terms
  logic        status_known;
  logic        fields_zero;
  logic        result_stuck;
  logic        last_waiting;

  qpp_front u_front (
    .query      (query),
    .item_valid (fr_valid),
    .item       (fr_item),
    .item_ready (fr_ready)
  );

  qpp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_item  (fr_item),
    .wr_ready (fr_ready),
    .rd_valid (bk_valid),
    .rd_item  (bk_item),
    .rd_ready (bk_ready),
    .stat     (q_stat)
  );

  qpp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rd_valid (bk_valid),
    .rd_item  (bk_item),
    .rd_ready (bk_ready),
    .result   (result)
  );

  assign status_known = (result.status == STATUS_OK) || (result.status == STATUS_BAD_PAGE) ||
                        (result.status == STATUS_BAD_SIZE);
  assign fields_zero  = (result.page_number == '0) && (result.page_size == '0);
  assign result_stuck = result.valid && !result.ready;
  assign last_waiting = bk_valid && bk_item.last;

  // Status is always one of the three defined codes
  `QPP_ASSERT_IMPLIES(a_status_code, result.valid, status_known, "undefined status code")
  // Error results carry zero fields
  `QPP_ASSERT_IMPLIES(a_error_zero, result.valid && result.status != STATUS_OK, fields_zero, "error result with nonzero fields")
  // Queue flags are consistent
  `QPP_ASSERT_ALWAYS(a_queue_flags, !(q_stat.full && q_stat.empty), "queue full and empty")
  // A transaction that ends a query is never taken by the back end while a result is stuck
  `QPP_ASSERT_NEXT(a_no_overrun, result_stuck && last_waiting, result.valid, "result dropped under stall")

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

// Testbench for query_pagination_parser_core.
module tb_top;
  import qpp_pkg::*;

  // Watchdog: cycles in a row with no transaction on any channel.
  localparam int STALL_LIMIT = 4000;
  // Length of the long result-side hold in the pressure phase.
  localparam int HOLD_CYCLES = 150;
  // Counted input transactions per random phase (has_byte or last_byte set).
  localparam int PHASE_ITEMS = 90;
  localparam int PHASES      = 8;

  localparam logic [31:0] VALUE_MAX = 32'hFFFF_FFFF;
  // Index with no register behind it; the write must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // Key names, first character in the top byte.
  localparam logic [31:0] KEY_PAGE = "page";
  localparam logic [31:0] KEY_SIZE = "size";

  typedef enum int {
    MODE_FREE,
    MODE_SEND_GAPS,
    MODE_RECV_STALLS,
    MODE_BOTH
  } traffic_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] number;
    logic [31:0] size;
  } page_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
  } query_item_t;

  typedef struct {
    string        text;
    bit           empty_end;  // close with a has_byte=0 / last_byte=1 transaction
    int           gap_at;     // idle has_byte=0 transaction before this char, -1 none
    bit           typed;      // expectation written in the row, not predicted
    page_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  qpp_in_if  query_ch ();
  qpp_out_if result_ch ();
  qpp_cfg_if cfg_ch ();

  query_pagination_parser_core u_top (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pagination predictor: configuration copy and per-query parse state
  // ---------------------------------------------------------------------------
  logic [31:0] set_default_page;
  logic [31:0] set_fallback_size;
  logic [31:0] set_size_limit;

  logic        in_val;     // past the '=' of the current pair
  logic [2:0]  key_len;    // key chars seen (sat. at 4); in value: digit seen
  logic        may_page;
  logic        may_size;
  logic [31:0] acc;
  logic        acc_ok;     // value still all digits and inside 32 bits
  logic        pg_seen, sz_seen;
  logic        pg_ok, sz_ok;
  logic [31:0] pg_val, sz_val;

  page_result_t pending_results[$];  // expected results, oldest first
  page_result_t head_result;

  traffic_t mode = MODE_FREE;
  int       err_count     = 0;
  int       items_sent    = 0;
  int       hold_requests = 0;
  int       holds_served  = 0;
  int       hold_left     = 0;
  int       quiet_cycles  = 0;

  logic [7:0]    qtext[$];        // characters of the query being built
  query_item_t   query_items[$];  // its transactions, gaps and end included
  directed_row_t directed_rows[$];

  function void open_pair();
    in_val   = 1'b0;
    key_len  = '0;
    may_page = 1'b1;
    may_size = 1'b1;
    acc      = '0;
    acc_ok   = 1'b0;
  endfunction

  function void clear_query();
    open_pair();
    pg_seen = 1'b0;
    sz_seen = 1'b0;
    pg_ok   = 1'b0;
    sz_ok   = 1'b0;
    pg_val  = '0;
    sz_val  = '0;
  endfunction

  // A pair ends at '&' or at the end of the query. Only pairs that had an '='
  // count; the first "page" wins, then the first "size".
  function void close_pair();
    if (in_val) begin
      if (may_page && !pg_seen) begin
        pg_seen = 1'b1;
        pg_val  = acc;
        pg_ok   = acc_ok && key_len != 0;
      end else if (may_size && !sz_seen) begin
        sz_seen = 1'b1;
        sz_val  = acc;
        sz_ok   = acc_ok && key_len != 0;
      end
    end
    open_pair();
  endfunction

  function void feed_char(logic [7:0] c);
    logic [31:0] d;
    logic        full;
    d = 32'(c) - 32'(CH_ZERO);
    if (c == CH_AMP) begin
      close_pair();
    end else if (!in_val) begin
      if (c == CH_EQ) begin
        full     = key_len == KEY_LEN;
        may_page = may_page && full;
        may_size = may_size && full;
        in_val   = 1'b1;
        key_len  = '0;
        acc      = '0;
        acc_ok   = 1'b1;
      end else if (key_len < KEY_LEN) begin
        if (c != KEY_PAGE[31 - 8 * key_len -: 8]) may_page = 1'b0;
        if (c != KEY_SIZE[31 - 8 * key_len -: 8]) may_size = 1'b0;
        key_len = key_len + 1'b1;
      end else begin
        may_page = 1'b0;
        may_size = 1'b0;
      end
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      key_len = 3'd1;
      if (acc_ok) begin
        // would acc*10 + d leave 32 bits
        if (acc > (VALUE_MAX - d) / 10) acc_ok = 1'b0;
        else acc = acc * 10 + d;
      end
    end else begin
      // any non-digit, a second '=' included, spoils the value
      acc_ok = 1'b0;
    end
  endfunction

  // End of query: page is judged first, then size; error results carry zeros.
  function page_result_t close_query();
    page_result_t r;
    close_pair();
    r = '0;
    if (pg_seen && (!pg_ok || pg_val == 0)) begin
      r.status = STATUS_BAD_PAGE;
    end else if (sz_seen && (!sz_ok || sz_val == 0 || sz_val > set_size_limit)) begin
      r.status = STATUS_BAD_SIZE;
    end else begin
      r.status = STATUS_OK;
      r.number = pg_seen ? pg_val : set_default_page;
      r.size   = sz_seen ? sz_val : set_fallback_size;
    end
    clear_query();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Query text construction
  // ---------------------------------------------------------------------------
  function void put_text(string s);
    for (int i = 0; i < s.len(); i++) qtext.push_back(s[i]);
  endfunction

  // Mostly the two real keys, plus near misses and odd keys.
  function void put_key();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4: put_text("page");
      5, 6, 7, 8:    put_text("size");
      9:             put_text("pag");
      10:            put_text("pagex");
      11:            put_text("Page");
      12:            put_text("sizee");
      13:            put_text("siz");
      14:            ;  // empty key
      default: begin
        repeat ($urandom_range(1, 6)) qtext.push_back(8'($urandom_range(97, 122)));
      end
    endcase
  endfunction

  function void put_junk_char();
    case ($urandom_range(0, 4))
      0:       qtext.push_back("-");
      1:       qtext.push_back("+");
      2:       qtext.push_back(CH_EQ);
      3:       qtext.push_back(" ");
      default: qtext.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // Values aimed at the interesting edges: zero, the size limit +-1, the 32-bit
  // limit and one past it, empty, and digits broken by a non-digit.
  function void put_value();
    logic [63:0] wide;
    logic [31:0] word;
    wide = {32'd0, set_size_limit} + 64'($urandom_range(0, 2)) - 64'd1;
    word = $urandom;
    case ($urandom_range(0, 11))
      0:  put_text("0");
      1:  put_text($sformatf("%0d", $urandom_range(1, 9)));
      2:  put_text($sformatf("%0d", $urandom_range(10, 999)));
      3:  put_text($sformatf("00%0d", $urandom_range(0, 99)));
      4:  put_text($sformatf("%0d", wide));
      5:  put_text("4294967295");
      6:  put_text("4294967296");
      7:  put_text($sformatf("%0d", word));
      8:  put_text("184467440737095516150");
      9:  ;  // empty value
      10: begin
        if ($urandom_range(0, 1) == 1) put_text($sformatf("%0d", $urandom_range(0, 99)));
        put_junk_char();
        if ($urandom_range(0, 1) == 1) put_text($sformatf("%0d", $urandom_range(0, 99)));
      end
      default: put_text($sformatf("%0d", $urandom_range(1, 20)));
    endcase
  endfunction

  // Turn qtext into transactions, with an optional idle has_byte=0 transaction
  // and either the last char or a char-less transaction ending the query.
  function void shape_query(int gap_at, bit empty_end);
    query_item_t it;
    query_items.delete();
    for (int i = 0; i < qtext.size(); i++) begin
      if (i == gap_at) begin
        it = '{ch: 8'($urandom_range(0, 255)), has: 1'b0, last: 1'b0};
        query_items.push_back(it);
      end
      it = '{ch: qtext[i], has: 1'b1, last: 1'b0};
      query_items.push_back(it);
    end
    if (empty_end || qtext.size() == 0) begin
      it = '{ch: 8'($urandom_range(0, 255)), has: 1'b0, last: 1'b1};
      query_items.push_back(it);
    end else begin
      query_items[query_items.size() - 1].last = 1'b1;
    end
  endfunction

  // Random query: mostly well-formed pairs with random content, some pairs
  // without '=', some junk, and now and then pure byte noise.
  function void build_query();
    int npairs;
    int kind;
    qtext.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) qtext.push_back(8'($urandom_range(0, 255)));
    end else begin
      npairs = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) qtext.push_back(CH_AMP);
      for (int p = 0; p < npairs; p++) begin
        if (p != 0) qtext.push_back(CH_AMP);
        kind = $urandom_range(0, 19);
        if (kind < 17) begin
          put_key();
          qtext.push_back(CH_EQ);
          put_value();
        end else if (kind == 17) begin
          put_key();
        end else begin
          repeat ($urandom_range(1, 4)) qtext.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 9) == 0) qtext.push_back(CH_AMP);
    end
    shape_query(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, qtext.size())) : -1,
                $urandom_range(0, 7) == 0);
  endfunction

  task automatic add_row(string text, bit empty_end, int gap_at, bit typed,
                         logic [1:0] st, logic [31:0] num, logic [31:0] sz);
    directed_row_t row;
    row.text        = text;
    row.empty_end   = empty_end;
    row.gap_at      = gap_at;
    row.typed       = typed;
    row.want.status = st;
    row.want.number = num;
    row.want.size   = sz;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Query side driver
  // ---------------------------------------------------------------------------
  function bit sender_waits();
    case (mode)
      MODE_SEND_GAPS: return $urandom_range(0, 99) < 84;
      MODE_BOTH:      return $urandom_range(0, 99) < 11;
      default:        return 1'b0;
    endcase
  endfunction

  // Offer one transaction, predict on acceptance. A typed expectation replaces
  // the prediction on the query's last transaction; the predictor still runs
  // so its state stays in step.
  task automatic send_item(query_item_t it, bit typed, page_result_t want);
    page_result_t r;
    while (sender_waits()) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid      <= 1'b1;
    query_ch.query_byte <= it.ch;
    query_ch.has_byte   <= it.has;
    query_ch.last_byte  <= it.last;
    do @(posedge clk); while (!query_ch.ready);
    if (it.has || it.last) items_sent++;
    if (it.has) feed_char(it.ch);
    if (it.last) begin
      r = close_query();
      if (typed) r = want;
      pending_results.push_back(r);
    end
  endtask

  task automatic send_query(bit typed, page_result_t want);
    foreach (query_items[i]) send_item(query_items[i], typed, want);
  endtask

  // Block idle: every result back, then a settling wait for the two-stage pipe.
  task automatic drain();
    query_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register writes
  // ---------------------------------------------------------------------------
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_DEFAULT_PAGE:  set_default_page  = value;
      CFG_FALLBACK_SIZE: set_fallback_size = value;
      CFG_SIZE_LIMIT:    set_size_limit    = value;
      default:           ;  // no register, write dropped
    endcase
  endtask

  // valid stays high across the back-to-back writes and drops once at the end
  task automatic load_settings(logic [31:0] dp, logic [31:0] ds, logic [31:0] ms,
                               bit poke_unused);
    put_reg(CFG_DEFAULT_PAGE, dp);
    put_reg(CFG_SIZE_LIMIT, ms);
    put_reg(CFG_FALLBACK_SIZE, ds);
    if (poke_unused) put_reg(CFG_UNUSED, $urandom);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checker and ready generation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no query pending, page_number",
                        result_ch.page_number, '0);
      end else begin
        head_result = pending_results.pop_front();
        if (result_ch.status !== head_result.status)
          report_mismatch("status", 32'(result_ch.status), 32'(head_result.status));
        if (result_ch.page_number !== head_result.number)
          report_mismatch("page_number", result_ch.page_number, head_result.number);
        if (result_ch.page_size !== head_result.size)
          report_mismatch("page_size", result_ch.page_size, head_result.size);
      end
    end
    // A pending hold request starts a long stretch of ready low; the queue in
    // front of the output register fills and the block stops taking bytes.
    if (holds_served != hold_requests) begin
      holds_served    <= holds_served + 1;
      hold_left       <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      case (mode)
        MODE_RECV_STALLS: result_ch.ready <= $urandom_range(0, 99) >= 84;
        MODE_BOTH:        result_ch.ready <= $urandom_range(0, 99) >= 11;
        default:          result_ch.ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: ends the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] dp, ds, ms;
    bit          poke;
    int          phase_start;

    rst                 = 1'b1;
    query_ch.valid      = 1'b0;
    query_ch.query_byte = '0;
    query_ch.has_byte   = 1'b0;
    query_ch.last_byte  = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    set_default_page    = RST_DEFAULT_PAGE;
    set_fallback_size   = RST_FALLBACK_SIZE;
    set_size_limit      = RST_SIZE_LIMIT;
    clear_query();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed queries at reset settings (page 1, size 20, max 100).
    add_row("", 1, -1, 1, STATUS_OK, 32'd1, 32'd20);                 // empty query
    add_row("page=0", 0, -1, 1, STATUS_BAD_PAGE, '0, '0);
    add_row("page=4294967295&size=100", 0, -1, 1, STATUS_OK, VALUE_MAX, 32'd100);
    add_row("page=4294967296", 0, -1, 1, STATUS_BAD_PAGE, '0, '0);  // too wide
    add_row("size=101", 0, -1, 1, STATUS_BAD_SIZE, '0, '0);
    add_row("size=0&page=0", 0, -1, 1, STATUS_BAD_PAGE, '0, '0);    // page judged first
    add_row("page=7&page=0&size=5&size=500", 0, -1, 1, STATUS_OK, 32'd7, 32'd5);
    add_row("page&size=3", 0, -1, 1, STATUS_OK, 32'd1, 32'd3);      // no '=', skipped
    add_row("page=1=2", 0, -1, 1, STATUS_BAD_PAGE, '0, '0);         // second '='
    add_row("page=", 0, -1, 1, STATUS_BAD_PAGE, '0, '0);
    add_row("pages=3&x=9&size=007", 0, -1, 1, STATUS_OK, 32'd1, 32'd7);
    add_row("page=-1", 0, -1, 1, STATUS_BAD_PAGE, '0, '0);
    add_row("page=2&size=x", 0, 3, 1, STATUS_BAD_SIZE, '0, '0);     // idle byte inside
    add_row("=&&pag=4&", 1, 0, 1, STATUS_OK, 32'd1, 32'd20);
    add_row("&size=99&page=0012&", 0, -1, 0, STATUS_OK, '0, '0);
    add_row("Page=9&SIZE=9&size=1", 0, 2, 0, STATUS_OK, '0, '0);
    add_row("size=100&page=1", 1, -1, 0, STATUS_OK, '0, '0);
    foreach (directed_rows[i]) begin
      qtext.delete();
      put_text(directed_rows[i].text);
      shape_query(directed_rows[i].gap_at, directed_rows[i].empty_end);
      send_query(directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    // Random phases, each with its own register settings and traffic shape.
    for (int ph = 0; ph < PHASES; ph++) begin
      poke = 1'b0;
      case (ph)
        0: begin
          dp = '0; ds = 32'd1; ms = 32'd1;  // low extremes
          mode = MODE_SEND_GAPS;
        end
        1: begin
          dp = VALUE_MAX; ds = VALUE_MAX; ms = VALUE_MAX;  // high extremes
          mode = MODE_RECV_STALLS;
        end
        2: begin
          dp = 32'd5; ds = 32'd10; ms = 32'd50; poke = 1'b1;
          mode = MODE_BOTH;
        end
        3: begin
          // back to the reset values; long result hold while bytes keep coming
          dp = RST_DEFAULT_PAGE; ds = RST_FALLBACK_SIZE; ms = RST_SIZE_LIMIT;
          mode = MODE_FREE;
          hold_requests <= hold_requests + 1;
        end
        4: begin
          dp = $urandom; ds = $urandom_range(1, 300); ms = $urandom_range(1, 300);
          mode = MODE_SEND_GAPS;
        end
        5: begin
          dp = $urandom_range(0, 9); ds = $urandom_range(1, VALUE_MAX);
          ms = $urandom_range(1, 1000);
          mode = MODE_RECV_STALLS;
        end
        6: begin
          dp = 32'd7; ds = 32'd3; ms = 32'h8000_0000;
          mode = MODE_BOTH;
        end
        default: begin
          dp = $urandom; ds = $urandom_range(1, 60); ms = $urandom_range(1, 60);
          mode = MODE_FREE;
          poke = 1'b1;
        end
      endcase
      load_settings(dp, ds, ms, poke);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_query();
        send_query(1'b0, '0);
      end
      drain();
    end

    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
